>>> design/defs_pkg.sv
// ----------------------------------------------------------------------------
// defs_pkg
// Shared types for the delayed event flag scheduler: operation codes,
// controller states and the command/status bundles between the control
// state machine and the datapath.
// ----------------------------------------------------------------------------
package defs_pkg;

    localparam int unsigned FLAG_W  = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DMS_W   = 24;
    localparam int unsigned DFR_W   = 8;
    localparam int unsigned FUNC_W  = 3;

    // operation codes carried on the func field
    typedef enum logic [FUNC_W-1:0] {
        FN_SET          = 3'd0,
        FN_AFTER_FRAMES = 3'd1,
        FN_AFTER_TIME   = 3'd2,
        FN_CHECK        = 3'd3,
        FN_HANDLE       = 3'd4,
        FN_CLEAR        = 3'd5,
        FN_TICK         = 3'd6
    } func_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;         // request accepted this cycle
        logic walk;         // table walk in progress
        logic walk_end;     // walk finished, commit compacted counts
        logic load_result;  // move result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;    // all entries read and evaluated
        logic out_busy;     // output register holds a result not yet taken
    } dp_status_t;

endpackage

>>> design/defs_ctrl.sv
// ----------------------------------------------------------------------------
// defs_ctrl
// Control state machine: accepts a request, runs the table walk for a frame
// tick, and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module defs_ctrl
    import defs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [FUNC_W-1:0]   s_func,
    output logic                s_ready,
    input  dp_status_t          status,
    output dp_cmd_t             cmd,
    output ctrl_state_t         state
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (s_func == FN_TICK) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_done) begin
                    cmd.walk_end = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

>>> design/defs_datapath.sv
// ----------------------------------------------------------------------------
// defs_datapath
// Flag register, frame counter, the two pending tables held in memories,
// the compacting walk that fires due entries, and the output register.
// ----------------------------------------------------------------------------
module defs_datapath
    import defs_pkg::*;
#(
    parameter int unsigned PENDING_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [FLAG_W-1:0]   s_event_mask,
    input  logic [DFR_W-1:0]    s_delay_frames,
    input  logic [DMS_W-1:0]    s_delay_ms,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic                m_ready,
    output logic                m_valid,
    output logic                m_happened,
    output logic [FLAG_W-1:0]   m_active_flags,
    output logic                m_dropped
);

    localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(PENDING_DEPTH);

    func_t fn;
    assign fn = func_t'(s_func);

    // pending table memories
    logic [TIME_W-1:0] f_dl_mem   [PENDING_DEPTH];
    logic [FLAG_W-1:0] f_mask_mem [PENDING_DEPTH];
    logic [TIME_W-1:0] t_dl_mem   [PENDING_DEPTH];
    logic [FLAG_W-1:0] t_mask_mem [PENDING_DEPTH];

    logic [FLAG_W-1:0] active_reg,  active_next;
    logic [TIME_W-1:0] fcount_reg,  fcount_next;
    logic [CW-1:0]     fcnt_reg,    fcnt_next;
    logic [CW-1:0]     tcnt_reg,    tcnt_next;
    logic              happened_reg, happened_next;
    logic              dropped_reg, dropped_next;
    logic [TIME_W-1:0] now_reg,     now_next;
    logic [CW-1:0]     idx_reg,     idx_next;
    logic [CW-1:0]     f_wptr_reg,  f_wptr_next;
    logic [CW-1:0]     t_wptr_reg,  t_wptr_next;
    logic              f_rv_reg,    t_rv_reg;
    logic [TIME_W-1:0] f_rd_dl_reg, t_rd_dl_reg;
    logic [FLAG_W-1:0] f_rd_mask_reg, t_rd_mask_reg;
    logic              m_valid_reg, m_valid_next;
    logic              m_happened_reg;
    logic [FLAG_W-1:0] m_flags_reg;
    logic              m_dropped_reg;

    logic              f_re, t_re;
    logic              f_we, t_we;
    logic [AW-1:0]     f_waddr, t_waddr;
    logic [TIME_W-1:0] f_wdl, t_wdl;
    logic [FLAG_W-1:0] f_wmask, t_wmask;
    logic [TIME_W:0]   t_sum;
    logic [TIME_W-1:0] t_deadline;
    logic              hit;

    // saturating time deadline
    assign t_sum      = {1'b0, s_now_ms} + {{(TIME_W + 1 - DMS_W){1'b0}}, s_delay_ms};
    assign t_deadline = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
    assign hit        = |(active_reg & s_event_mask);

    // walk read enables
    assign f_re = cmd.walk && (idx_reg < fcnt_reg);
    assign t_re = cmd.walk && (idx_reg < tcnt_reg);

    // operation decode, walk evaluation and compaction
    always_comb begin
        active_next   = active_reg;
        fcount_next   = fcount_reg;
        fcnt_next     = fcnt_reg;
        tcnt_next     = tcnt_reg;
        happened_next = happened_reg;
        dropped_next  = dropped_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        f_wptr_next   = f_wptr_reg;
        t_wptr_next   = t_wptr_reg;
        f_we          = 1'b0;
        t_we          = 1'b0;
        f_waddr       = fcnt_reg[AW-1:0];
        t_waddr       = tcnt_reg[AW-1:0];
        f_wdl         = fcount_reg + {{(TIME_W - DFR_W){1'b0}}, s_delay_frames};
        t_wdl         = t_deadline;
        f_wmask       = s_event_mask;
        t_wmask       = s_event_mask;

        if (cmd.take) begin
            happened_next = 1'b0;
            dropped_next  = 1'b0;
            unique case (fn)
                FN_SET: begin
                    active_next = active_reg | s_event_mask;
                end
                FN_AFTER_FRAMES: begin
                    if (fcnt_reg == FULL_COUNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        f_we      = 1'b1;
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
                FN_AFTER_TIME: begin
                    if (tcnt_reg == FULL_COUNT) begin
                        dropped_next = 1'b1;
                    end else begin
                        t_we      = 1'b1;
                        tcnt_next = tcnt_reg + 1'b1;
                    end
                end
                FN_CHECK: begin
                    happened_next = hit;
                end
                FN_HANDLE: begin
                    happened_next = hit;
                    if (hit) begin
                        active_next = active_reg & ~s_event_mask;
                    end
                end
                FN_CLEAR: begin
                    active_next = '0;
                end
                FN_TICK: begin
                    fcount_next = fcount_reg + 1'b1;
                    now_next    = s_now_ms;
                    idx_next    = '0;
                    f_wptr_next = '0;
                    t_wptr_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.walk) begin
            if (f_re || t_re) begin
                idx_next = idx_reg + 1'b1;
            end
            // frame entry: fire on equal deadline, else keep it compacted
            if (f_rv_reg) begin
                if (f_rd_dl_reg == fcount_reg) begin
                    active_next = active_next | f_rd_mask_reg;
                end else begin
                    f_we        = 1'b1;
                    f_waddr     = f_wptr_reg[AW-1:0];
                    f_wdl       = f_rd_dl_reg;
                    f_wmask     = f_rd_mask_reg;
                    f_wptr_next = f_wptr_reg + 1'b1;
                end
            end
            // time entry: fire once now lies strictly above the deadline
            if (t_rv_reg) begin
                if (now_reg > t_rd_dl_reg) begin
                    active_next = active_next | t_rd_mask_reg;
                end else begin
                    t_we        = 1'b1;
                    t_waddr     = t_wptr_reg[AW-1:0];
                    t_wdl       = t_rd_dl_reg;
                    t_wmask     = t_rd_mask_reg;
                    t_wptr_next = t_wptr_reg + 1'b1;
                end
            end
        end

        if (cmd.walk_end) begin
            fcnt_next = f_wptr_reg;
            tcnt_next = t_wptr_reg;
        end
    end

    // output register next valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            fcount_reg  <= '0;
            fcnt_reg    <= '0;
            tcnt_reg    <= '0;
            idx_reg     <= '0;
            f_wptr_reg  <= '0;
            t_wptr_reg  <= '0;
            f_rv_reg    <= 1'b0;
            t_rv_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            fcount_reg  <= fcount_next;
            fcnt_reg    <= fcnt_next;
            tcnt_reg    <= tcnt_next;
            idx_reg     <= idx_next;
            f_wptr_reg  <= f_wptr_next;
            t_wptr_reg  <= t_wptr_next;
            f_rv_reg    <= f_re;
            t_rv_reg    <= t_re;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        happened_reg <= happened_next;
        dropped_reg  <= dropped_next;
        now_reg      <= now_next;
        if (cmd.load_result) begin
            m_happened_reg <= happened_reg;
            m_flags_reg    <= active_reg;
            m_dropped_reg  <= dropped_reg;
        end
    end

    // frame table memory
    always_ff @(posedge aclk) begin
        if (f_we) begin
            f_dl_mem[f_waddr]   <= f_wdl;
            f_mask_mem[f_waddr] <= f_wmask;
        end
        if (f_re) begin
            f_rd_dl_reg   <= f_dl_mem[idx_reg[AW-1:0]];
            f_rd_mask_reg <= f_mask_mem[idx_reg[AW-1:0]];
        end
    end

    // time table memory
    always_ff @(posedge aclk) begin
        if (t_we) begin
            t_dl_mem[t_waddr]   <= t_wdl;
            t_mask_mem[t_waddr] <= t_wmask;
        end
        if (t_re) begin
            t_rd_dl_reg   <= t_dl_mem[idx_reg[AW-1:0]];
            t_rd_mask_reg <= t_mask_mem[idx_reg[AW-1:0]];
        end
    end

    // status back to the controller
    always_comb begin
        status.walk_done = (idx_reg >= fcnt_reg) && (idx_reg >= tcnt_reg)
                           && !f_rv_reg && !t_rv_reg;
        status.out_busy  = m_valid_reg && !m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_happened     = m_happened_reg;
    assign m_active_flags = m_flags_reg;
    assign m_dropped      = m_dropped_reg;

endmodule

>>> design/delayed_event_flag_scheduler.sv
// ----------------------------------------------------------------------------
// delayed_event_flag_scheduler
// Keeps an 8-bit active flag mask plus frame-based and time-based pending
// tables; every request returns exactly one result with the updated flags.
// ----------------------------------------------------------------------------
// One request is handled at a time. A set, schedule, check, handle or clear
// request goes from acceptance to the result state, which moves its result
// into the output register; the next request can be accepted after that. A frame
// tick walks both pending tables side by side, one entry per cycle, through
// memories that take one read (with registered read data) and one compacting
// write per cycle. After the walk, the compacted counts are committed and the
// result state moves the result into the output register. A new request is
// accepted as soon as the previous result has moved to the output register,
// even if that result has not yet been taken; while an untaken result still
// holds the output register, the finished request waits and no new request
// is accepted.
module delayed_event_flag_scheduler
    import defs_pkg::*;
#(
    parameter int unsigned PENDING_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [FLAG_W-1:0]   s_event_mask,
    input  logic [DFR_W-1:0]    s_delay_frames,
    input  logic [DMS_W-1:0]    s_delay_ms,
    input  logic [TIME_W-1:0]   s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_happened,
    output logic [FLAG_W-1:0]   m_active_flags,
    output logic                m_dropped
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    ctrl_state_t state;

    // control state machine
    defs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    // flags, tables and output register
    defs_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_func         (s_func),
        .s_event_mask   (s_event_mask),
        .s_delay_frames (s_delay_frames),
        .s_delay_ms     (s_delay_ms),
        .s_now_ms       (s_now_ms),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_happened     (m_happened),
        .m_active_flags (m_active_flags),
        .m_dropped      (m_dropped)
    );

    // a frame tick always goes through the walk, so no request follows at once
    a_tick_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FN_TICK)) |=> (state == ST_WALK) && !s_ready)
        else $error("frame tick request did not start a table walk");

    // a request never both tests flags and reports a full table
    a_result_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_happened && m_dropped))
        else $error("result reports both happened and dropped");

    // a result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_result) |-> !(m_valid && !m_ready))
        else $error("pending result overwritten");

endmodule
